[sv/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and types for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CALIB    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CALIB_A = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CALIB_B = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CALIB_C = 2'd3;

    // compensation constants
    localparam logic signed [24:0] FINE_OFFSET = 25'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic signed [63:0] PRESS_SCALE = 64'sd3125;
    localparam logic signed [63:0] V_BIAS      = 64'sh0000_8000_0000_0000; // 2^47
    localparam int                 P4_SHIFT    = 35;
    localparam int                 V_SHIFT     = 33;

    // pipeline shape
    localparam int FRONT_STAGES       = 11;
    localparam int BACK_STAGES        = 5;
    localparam int DIV_WIDTH          = 64;
    localparam int DIVISOR_W          = 31;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_WIDTH / DIV_BITS_PER_STAGE;

    // sideband that rides through the divider
    typedef struct packed {
        logic               neg;
        logic               zero;
        logic signed [15:0] temp;
    } div_side_t;

endpackage

[sv/bsc_div.sv]
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined unsigned restoring divider, a fixed number of quotient bits per
// stage, with a sideband carried alongside each item.
// ----------------------------------------------------------------------------
module bsc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [bsc_pkg::DIV_WIDTH-1:0] in_dividend,
    input  logic [bsc_pkg::DIVISOR_W-1:0] in_divisor,
    input  bsc_pkg::div_side_t            in_side,
    output logic                          out_valid,
    output logic [bsc_pkg::DIV_WIDTH-1:0] out_quotient,
    output bsc_pkg::div_side_t            out_side
);
    import bsc_pkg::*;

    logic [DIV_STAGES-1:0]  vld_reg;
    logic [DIVISOR_W-1:0]   rem_reg  [DIV_STAGES];
    logic [DIVISOR_W-1:0]   rem_next [DIV_STAGES];
    logic [DIV_WIDTH-1:0]   word_reg [DIV_STAGES];
    logic [DIV_WIDTH-1:0]   word_next[DIV_STAGES];
    logic [DIVISOR_W-1:0]   dvs_reg  [DIV_STAGES-1];
    div_side_t              side_reg [DIV_STAGES];

    // word shifts left: dividend bits leave at the top, quotient bits enter below
    always_comb
    begin
        logic [DIVISOR_W-1:0] rem;
        logic [DIV_WIDTH-1:0] word;
        logic [DIVISOR_W-1:0] dvs;
        logic [DIVISOR_W:0]   trial;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem  = '0;
                word = in_dividend;
                dvs  = in_divisor;
            end
            else
            begin
                rem  = rem_reg[s-1];
                word = word_reg[s-1];
                dvs  = dvs_reg[s-1];
            end
            for (int k = 0; k < DIV_BITS_PER_STAGE; k++)
            begin
                trial = {rem, word[DIV_WIDTH-1]};
                word  = {word[DIV_WIDTH-2:0], 1'b0};
                if (trial >= {1'b0, dvs})
                begin
                    rem     = DIVISOR_W'(trial - {1'b0, dvs});
                    word[0] = 1'b1;
                end
                else
                begin
                    rem = trial[DIVISOR_W-1:0];
                end
            end
            rem_next[s]  = rem;
            word_next[s] = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            dvs_reg[0]  <= in_divisor;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                word_reg[s] <= word_next[s];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 1; s < DIV_STAGES - 1; s++)
            begin
                dvs_reg[s] <= dvs_reg[s-1];
            end
        end
    end

    assign out_valid    = vld_reg[DIV_STAGES-1];
    assign out_quotient = word_reg[DIV_STAGES-1];
    assign out_side     = side_reg[DIV_STAGES-1];

endmodule

[sv/barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// 64-bit integer temperature and pressure compensation of raw 20-bit readings.
// ----------------------------------------------------------------------------
// One reading pair per transfer; one result per reading pair, in order. The
// pipeline takes a new pair every cycle while the output is not stalled, and
// each pair passes through 11 stages of temperature and pressure polynomials,
// 32 divider stages (two quotient bits each, a 32-bit compare-subtract per
// bit), then 5 stages of pressure correction.
// A stall on the output freezes the whole pipeline, so in_ready follows
// out_ready while a result is waiting. Calibration writes are taken every
// cycle (cfg_ready is tied high) and must only be issued while the block is
// empty. Temperature is in 0.01 degC saturated to 16 bits; pressure is
// unsigned Q24.8 Pa. When the pressure divisor works out to zero, pressure
// reads 0 and divisor_zero is set; temperature is still valid.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  logic                            clk,
    input  logic                            rst_n,
    // calibration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    // reading pair in
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [19:0]                     raw_temperature,
    input  logic [19:0]                     raw_pressure,
    // result out
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              temperature_centi,
    output logic [31:0]                     pressure_q24_8,
    output logic                            divisor_zero
);
    import bsc_pkg::*;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [47:0] temp_calib_reg;
    logic [63:0] press_calib_a_reg;
    logic [63:0] press_calib_b_reg;
    logic [15:0] press_calib_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg    <= '0;
            press_calib_a_reg <= '0;
            press_calib_b_reg <= '0;
            press_calib_c_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TEMP_CALIB:    temp_calib_reg    <= cfg_data[47:0];
                CFG_PRESS_CALIB_A: press_calib_a_reg <= cfg_data;
                CFG_PRESS_CALIB_B: press_calib_b_reg <= cfg_data;
                CFG_PRESS_CALIB_C: press_calib_c_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // calibration words
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = $signed(temp_calib_reg[31:16]);
    assign t3 = $signed(temp_calib_reg[47:32]);
    assign p1 = press_calib_a_reg[15:0];
    assign p2 = $signed(press_calib_a_reg[31:16]);
    assign p3 = $signed(press_calib_a_reg[47:32]);
    assign p4 = $signed(press_calib_a_reg[63:48]);
    assign p5 = $signed(press_calib_b_reg[15:0]);
    assign p6 = $signed(press_calib_b_reg[31:16]);
    assign p7 = $signed(press_calib_b_reg[47:32]);
    assign p8 = $signed(press_calib_b_reg[63:48]);
    assign p9 = $signed(press_calib_c_reg);

    // ------------------------------------------------------------------
    // flow control: one enable for every stage
    // ------------------------------------------------------------------
    logic                    adv;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [BACK_STAGES-1:0]  vback_reg;

    assign adv      = !vback_reg[BACK_STAGES-1] || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // front stages: temperature, then pressure divisor and dividend
    // ------------------------------------------------------------------
    // s1
    logic signed [18:0] tdiff_reg, tdiff_next;
    logic signed [17:0] d_reg, d_next;
    logic [20:0]        pfull_next;
    logic [20:0]        pfull_reg [8];     // carried s1..s8
    // s2
    logic signed [34:0] aprod_reg, aprod_next;
    logic signed [35:0] dd_full;
    logic [31:0]        dd_reg, dd_next;
    // s3
    logic signed [34:0] a_full;
    logic signed [23:0] a_reg, a_next;
    logic signed [36:0] bprod_reg, bprod_next;
    // s4
    logic signed [36:0] b_sh;
    logic signed [23:0] fine_reg, fine_next;
    // s5
    logic signed [27:0] tscaled, tc;
    logic signed [15:0] temp_next;
    logic signed [15:0] temp_line_reg [6]; // carried s5..s10
    logic signed [24:0] x1_reg, x1_next;
    // s6
    logic signed [49:0] xx_reg, xx_next;
    logic signed [40:0] xp5_reg, xp5_next, xp2_reg, xp2_next;
    // s7
    logic signed [63:0] y6_reg, y6_next, xx3_reg, xx3_next;
    logic signed [40:0] xp5_s7_reg, xp2_s7_reg;
    // s8
    logic signed [63:0] y_reg, y_next, xsum, v_full;
    logic signed [55:0] v_reg, v_next;
    // s9
    logic signed [63:0] vp_reg, vp_next, pd_reg, pd_next;
    // s10
    logic signed [63:0] x2_full;
    logic signed [30:0] x2_reg, x2_next;
    logic signed [63:0] num_reg, num_next;
    // s11
    logic [63:0]        mag_reg, mag_next;
    logic [30:0]        dvs_reg, dvs_next;
    div_side_t          side_reg, side_next;

    always_comb
    begin
        // s1: offsets against T1, pressure headroom
        tdiff_next = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
        d_next     = $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, t1});
        pfull_next = PRESS_FULL - {1'b0, raw_pressure};

        // s2
        aprod_next = 35'(tdiff_reg) * 35'(t2);
        dd_full    = 36'(d_reg) * 36'(d_reg);
        dd_next    = dd_full[31:0];

        // s3
        a_full     = aprod_reg >>> 11;
        a_next     = a_full[23:0];
        bprod_next = 37'($signed({1'b0, dd_reg[31:12]})) * 37'(t3);

        // s4: fine temperature
        b_sh       = bprod_reg >>> 14;
        fine_next  = a_reg + $signed(b_sh[23:0]);

        // s5: centi-degrees with saturation
        tscaled = 28'(fine_reg) * 28'sd5 + 28'sd128;
        tc      = tscaled >>> 8;
        if (tc > 28'sd32767)
        begin
            temp_next = 16'sh7FFF;
        end
        else if (tc < -28'sd32768)
        begin
            temp_next = 16'sh8000;
        end
        else
        begin
            temp_next = tc[15:0];
        end
        x1_next = 25'(fine_reg) - FINE_OFFSET;

        // s6
        xx_next  = 50'(x1_reg) * 50'(x1_reg);
        xp5_next = 41'(x1_reg) * 41'(p5);
        xp2_next = 41'(x1_reg) * 41'(p2);

        // s7
        y6_next  = 64'(xx_reg) * 64'(p6);
        xx3_next = 64'(xx_reg) * 64'(p3);

        // s8: dividend offset y and divisor polynomial
        y_next = y6_reg + (64'(xp5_s7_reg) <<< 17) + (64'(p4) <<< P4_SHIFT);
        xsum   = (xx3_reg >>> 8) + (64'(xp2_s7_reg) <<< 12);
        v_full = xsum + V_BIAS;
        v_next = v_full[55:0];

        // s9: wraps modulo 2^64
        vp_next = 64'(v_reg) * 64'($signed({1'b0, p1}));
        pd_next = $signed({12'd0, pfull_reg[7], 31'd0}) - y_reg;

        // s10
        x2_full  = vp_reg >>> V_SHIFT;
        x2_next  = x2_full[30:0];
        num_next = pd_reg * PRESS_SCALE;

        // s11: sign and magnitude for the divider
        mag_next = num_reg[63] ? (64'd0 - $unsigned(num_reg)) : $unsigned(num_reg);
        dvs_next = x2_reg[30] ? (31'd0 - $unsigned(x2_reg)) : $unsigned(x2_reg);
        side_next.neg  = num_reg[63] ^ x2_reg[30];
        side_next.zero = (x2_reg == 31'sd0);
        side_next.temp = temp_line_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tdiff_reg <= tdiff_next;
            d_reg     <= d_next;
            pfull_reg[0] <= pfull_next;
            for (int i = 1; i < 8; i++)
            begin
                pfull_reg[i] <= pfull_reg[i-1];
            end
            aprod_reg <= aprod_next;
            dd_reg    <= dd_next;
            a_reg     <= a_next;
            bprod_reg <= bprod_next;
            fine_reg  <= fine_next;
            temp_line_reg[0] <= temp_next;
            for (int i = 1; i < 6; i++)
            begin
                temp_line_reg[i] <= temp_line_reg[i-1];
            end
            x1_reg     <= x1_next;
            xx_reg     <= xx_next;
            xp5_reg    <= xp5_next;
            xp2_reg    <= xp2_next;
            y6_reg     <= y6_next;
            xx3_reg    <= xx3_next;
            xp5_s7_reg <= xp5_reg;
            xp2_s7_reg <= xp2_reg;
            y_reg      <= y_next;
            v_reg      <= v_next;
            vp_reg     <= vp_next;
            pd_reg     <= pd_next;
            x2_reg     <= x2_next;
            num_reg    <= num_next;
            mag_reg    <= mag_next;
            dvs_reg    <= dvs_next;
            side_reg   <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic        div_valid;
    logic [63:0] div_q;
    div_side_t   div_side;

    bsc_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (vld_reg[FRONT_STAGES-1]),
        .in_dividend  (mag_reg),
        .in_divisor   (dvs_reg),
        .in_side      (side_reg),
        .out_valid    (div_valid),
        .out_quotient (div_q),
        .out_side     (div_side)
    );

    // ------------------------------------------------------------------
    // back stages: second-order pressure correction
    // ------------------------------------------------------------------
    logic signed [63:0] p_reg, p_next;
    logic signed [63:0] s13_full;
    logic signed [50:0] s13_reg;
    logic signed [63:0] s13x;
    logic signed [63:0] m1_reg, m1_next, pp8_reg, pp8_next, p2_reg;
    logic [63:0]        ll_reg, ll_next;
    logic [31:0]        lh_reg, lh_next, hl_reg, hl_next;
    logic signed [63:0] pp8_3_reg, p3_reg;
    logic signed [63:0] m2_reg, m2_next, pb_reg, pb_next;
    logic signed [63:0] sum;
    logic [31:0]        press_val;
    logic [31:0]        press_reg, press_next;
    logic               back_zero_reg [BACK_STAGES];
    logic signed [15:0] back_temp_reg [BACK_STAGES];

    always_comb
    begin
        // P1: restore quotient sign
        p_next = div_side.neg ? $signed(64'd0 - div_q) : $signed(div_q);

        // P2
        s13_full = p_reg >>> 13;
        m1_next  = 64'(p9) * s13_full;
        pp8_next = p_reg * 64'(p8);

        // P3: low 64 bits of m1 * s13 from 32-bit partial products
        s13x    = 64'(s13_reg);
        ll_next = 64'(m1_reg[31:0]) * 64'(s13x[31:0]);
        lh_next = m1_reg[31:0] * s13x[63:32];
        hl_next = m1_reg[63:32] * s13x[31:0];

        // P4
        m2_next = $signed(ll_reg + {lh_reg + hl_reg, 32'd0});
        pb_next = p3_reg + (pp8_3_reg >>> 19);

        // P5: low 32 bits of (sum >> 8) + P7 * 16
        sum        = pb_reg + (m2_reg >>> 25);
        press_val  = sum[39:8] + ($unsigned(32'(p7)) << 4);
        press_next = back_zero_reg[BACK_STAGES-2] ? 32'd0 : press_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vback_reg <= '0;
        end
        else if (adv)
        begin
            vback_reg <= {vback_reg[BACK_STAGES-2:0], div_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg     <= p_next;
            s13_reg   <= s13_full[50:0];
            m1_reg    <= m1_next;
            pp8_reg   <= pp8_next;
            p2_reg    <= p_reg;
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            hl_reg    <= hl_next;
            pp8_3_reg <= pp8_reg;
            p3_reg    <= p2_reg;
            m2_reg    <= m2_next;
            pb_reg    <= pb_next;
            press_reg <= press_next;
            back_zero_reg[0] <= div_side.zero;
            back_temp_reg[0] <= div_side.temp;
            for (int i = 1; i < BACK_STAGES; i++)
            begin
                back_zero_reg[i] <= back_zero_reg[i-1];
                back_temp_reg[i] <= back_temp_reg[i-1];
            end
        end
    end

    // result register is the last back stage
    assign out_valid         = vback_reg[BACK_STAGES-1];
    assign temperature_centi = back_temp_reg[BACK_STAGES-1];
    assign pressure_q24_8    = press_reg;
    assign divisor_zero      = back_zero_reg[BACK_STAGES-1];

endmodule
